>>> rtl/core/bsnh_pkg.sv
// Package for the byte string noise hash: widths, mixer constants, sequencer
// types and the shift-xor mixing functions.
// No dependencies.
package bsnh_pkg;

    localparam int DATA_W = 8;
    localparam int HASH_W = 32;

    localparam logic [HASH_W-1:0] MIX_K1 = 32'hd2a8_0a3f;
    localparam logic [HASH_W-1:0] MIX_K2 = 32'ha884_f197;
    localparam logic [HASH_W-1:0] MIX_K3 = 32'h6c73_6f4b;
    localparam logic [HASH_W-1:0] MIX_K4 = 32'hb79f_3abb;
    localparam logic [HASH_W-1:0] MIX_K5 = 32'h1b56_c4f5;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Seven multiplies per byte: noise(h, s), h * noise, noise(s, h)
    typedef enum logic [2:0] {
        STEP_N1_K1 = 3'd0,
        STEP_N1_K3 = 3'd1,
        STEP_N1_K5 = 3'd2,
        STEP_H_MUL = 3'd3,
        STEP_N2_K1 = 3'd4,
        STEP_N2_K3 = 3'd5,
        STEP_N2_K5 = 3'd6
    } t_step;

    function automatic logic [HASH_W-1:0] mix_a(input logic [HASH_W-1:0] prod,
                                                input logic [HASH_W-1:0] seed);
        logic [HASH_W-1:0] m;
        m = prod + seed;
        m = m ^ (m >> 9);
        m = m + MIX_K2;
        m = m ^ (m >> 11);
        return m;
    endfunction

    function automatic logic [HASH_W-1:0] mix_b(input logic [HASH_W-1:0] prod);
        logic [HASH_W-1:0] m;
        m = prod ^ (prod >> 13);
        m = m + MIX_K4;
        m = m ^ (m >> 15);
        return m;
    endfunction

    function automatic logic [HASH_W-1:0] mix_c(input logic [HASH_W-1:0] prod);
        return prod ^ (prod >> 17);
    endfunction

endpackage

>>> rtl/core/bsnh_if.sv
// Valid/ready stream interfaces for the byte string noise hash: byte input
// and hash output channels. Depends on bsnh_pkg.
interface bsnh_in_if;
    logic                        valid;
    logic                        ready;
    logic [bsnh_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsnh_out_if;
    logic                        valid;
    logic                        ready;
    logic [bsnh_pkg::HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

>>> rtl/core/byte_string_noise_hash.sv
// Byte string noise hash: running 32-bit hash built on two noise mixer passes
// per byte. Depends on bsnh_pkg and the stream interfaces in bsnh_if.sv.
//
// Usage:
//   i_in carries one string byte per transaction (data_byte, last_byte).
//   o_out carries one transaction (hash_value) per string, after the byte
//   marked last; no output for other bytes.
//   After acceptance, each byte runs seven dependent 32x32 multiplies on
//   one shared multiplier, each in ST_MUL and followed by a mixing step in
//   ST_MIX, then ST_DONE closes the byte before i_in.ready rises again. A
//   new byte is accepted only in ST_IDLE, once the previous byte is through.
//   The hash of a string is presented on o_out when its last byte leaves
//   ST_DONE, in the same cycle that i_in.ready rises again.
//   The output register holds a finished hash while the receiver stalls; the
//   next string's bytes keep being accepted meanwhile. Only when a second
//   hash is finished before the first is taken does the block wait, with
//   i_in.ready low, until o_out.ready frees the register.
//   Reset (i_rst_n low, synchronous) clears the running hash to zero, drops
//   o_out.valid and returns the sequencer to idle.
module byte_string_noise_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsnh_in_if.sink     i_in,
    bsnh_out_if.source  o_out
);

    bsnh_pkg::t_state              r_state;
    bsnh_pkg::t_step               r_step;
    logic [bsnh_pkg::HASH_W-1:0]   r_s;
    logic                          r_last;
    logic [bsnh_pkg::HASH_W-1:0]   r_h;
    logic [bsnh_pkg::HASH_W-1:0]   r_m;
    logic [bsnh_pkg::HASH_W-1:0]   r_prod;
    logic                          r_out_valid;
    logic [bsnh_pkg::HASH_W-1:0]   r_out_hash;

    logic [bsnh_pkg::HASH_W-1:0]   mul_a;
    logic [bsnh_pkg::HASH_W-1:0]   mul_b;
    logic [bsnh_pkg::HASH_W-1:0]   mul_lo;
    logic [bsnh_pkg::HASH_W-1:0]   mix_out;
    logic [bsnh_pkg::HASH_W-1:0]   in_sext;
    logic                          out_free;
    logic                          out_load;

    assign i_in.ready       = (r_state == bsnh_pkg::ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;
    assign out_free         = !r_out_valid || o_out.ready;
    assign out_load         = (r_state == bsnh_pkg::ST_DONE) && r_last && out_free;
    assign in_sext          = {{(bsnh_pkg::HASH_W-bsnh_pkg::DATA_W)
                                {i_in.data_byte[bsnh_pkg::DATA_W-1]}}, i_in.data_byte};

    always_comb begin
        case (r_step)
            bsnh_pkg::STEP_N1_K1: begin
                mul_a = r_h;
                mul_b = bsnh_pkg::MIX_K1;
            end
            bsnh_pkg::STEP_N1_K3, bsnh_pkg::STEP_N2_K3: begin
                mul_a = r_m;
                mul_b = bsnh_pkg::MIX_K3;
            end
            bsnh_pkg::STEP_N1_K5, bsnh_pkg::STEP_N2_K5: begin
                mul_a = r_m;
                mul_b = bsnh_pkg::MIX_K5;
            end
            bsnh_pkg::STEP_H_MUL: begin
                mul_a = r_h;
                mul_b = r_m;
            end
            bsnh_pkg::STEP_N2_K1: begin
                mul_a = r_s;
                mul_b = bsnh_pkg::MIX_K1;
            end
            default: begin
                mul_a = r_m;
                mul_b = bsnh_pkg::MIX_K1;
            end
        endcase
    end

    assign mul_lo = mul_a * mul_b;

    always_comb begin
        case (r_step)
            bsnh_pkg::STEP_N1_K1:                       mix_out = bsnh_pkg::mix_a(r_prod, r_s);
            bsnh_pkg::STEP_N2_K1:                       mix_out = bsnh_pkg::mix_a(r_prod, r_h);
            bsnh_pkg::STEP_N1_K3, bsnh_pkg::STEP_N2_K3: mix_out = bsnh_pkg::mix_b(r_prod);
            bsnh_pkg::STEP_N1_K5, bsnh_pkg::STEP_N2_K5: mix_out = bsnh_pkg::mix_c(r_prod);
            default:                                    mix_out = r_prod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsnh_pkg::ST_IDLE;
            r_step      <= bsnh_pkg::STEP_N1_K1;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                bsnh_pkg::ST_IDLE: begin
                    if (i_in.valid) begin
                        r_s     <= in_sext;
                        r_last  <= i_in.last_byte;
                        r_step  <= bsnh_pkg::STEP_N1_K1;
                        r_state <= bsnh_pkg::ST_MUL;
                    end
                end
                bsnh_pkg::ST_MUL: begin
                    r_prod  <= mul_lo;
                    r_state <= bsnh_pkg::ST_MIX;
                end
                bsnh_pkg::ST_MIX: begin
                    case (r_step)
                        bsnh_pkg::STEP_H_MUL: r_h <= r_prod;
                        bsnh_pkg::STEP_N2_K5: r_h <= r_h ^ mix_out;
                        default:              r_m <= mix_out;
                    endcase
                    case (r_step)
                        bsnh_pkg::STEP_N1_K1: r_step <= bsnh_pkg::STEP_N1_K3;
                        bsnh_pkg::STEP_N1_K3: r_step <= bsnh_pkg::STEP_N1_K5;
                        bsnh_pkg::STEP_N1_K5: r_step <= bsnh_pkg::STEP_H_MUL;
                        bsnh_pkg::STEP_H_MUL: r_step <= bsnh_pkg::STEP_N2_K1;
                        bsnh_pkg::STEP_N2_K1: r_step <= bsnh_pkg::STEP_N2_K3;
                        bsnh_pkg::STEP_N2_K3: r_step <= bsnh_pkg::STEP_N2_K5;
                        default:              r_step <= bsnh_pkg::STEP_N1_K1;
                    endcase
                    r_state <= (r_step == bsnh_pkg::STEP_N2_K5) ? bsnh_pkg::ST_DONE
                                                                 : bsnh_pkg::ST_MUL;
                end
                bsnh_pkg::ST_DONE: begin
                    if (!r_last) begin
                        r_state <= bsnh_pkg::ST_IDLE;
                    end else if (out_free) begin
                        r_out_hash  <= r_h;
                        r_out_valid <= 1'b1;
                        r_h         <= '0;
                        r_state     <= bsnh_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= bsnh_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule
